// ----- rtl/flia_pkg.sv -----
// Shared constants and item types for the free list index allocator.
package flia_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int IDX_W     = $clog2(MAX_SLOTS);
    localparam int LINK_W    = IDX_W + 1;
    localparam int CNT_W     = IDX_W + 1;
    localparam int POOL_W    = 11;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 2;

    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REINIT  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    localparam logic [LINK_W-1:0] END_MARK      = LINK_W'(MAX_SLOTS);
    localparam logic [POOL_W-1:0] POOL_RESET    = POOL_W'(1024);
    localparam logic [POOL_W-1:0] POOL_MAX      = POOL_W'(MAX_SLOTS);
    localparam logic [CNT_W-1:0]  USED_MAX      = CNT_W'(MAX_SLOTS);

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  slot_index;
    } req_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]    granted_index;
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    used_slots;
    } rsp_item_t;

endpackage

// ----- rtl/free_list_index_allocator_top.sv -----
// Top level of the free list index allocator: sequencer plus link memory.
//
//   channel | direction | handshake              | item
//   req     | in        | req_valid / req_stall  | mode, slot_index
//   rsp     | out       | rsp_valid / rsp_stall  | granted_index, status, used_slots
//   cfg     | in        | cfg_we                 | pool_size
//
// Allocate, release and the unused mode go through S_IDLE and S_EXEC: the link of
// the head is read from the link memory on the accept edge and used in S_EXEC.
// Reinitialize then enters S_FILL, which rewrites one link per slot of the pool size.
// After reset the link memory is filled for all MAX_SLOTS (1024) slots before the
// first item is taken. A stalled result holds the next item in S_EXEC.
module free_list_index_allocator_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [flia_pkg::POOL_W-1:0] cfg_wdata,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  flia_pkg::req_item_t         req,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output flia_pkg::rsp_item_t         rsp
);

    logic                        ram_we;
    logic [flia_pkg::IDX_W-1:0]  ram_waddr;
    logic [flia_pkg::LINK_W-1:0] ram_wdata;
    logic [flia_pkg::IDX_W-1:0]  ram_raddr;
    logic [flia_pkg::LINK_W-1:0] ram_rdata;

    flia_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    flia_ram #(
        .WIDTH (flia_pkg::LINK_W),
        .DEPTH (flia_pkg::MAX_SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

// ----- rtl/flia_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module flia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/flia_ctrl.sv -----
// Free list sequencer: head, count, link fill sweep and result register.
module flia_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [flia_pkg::POOL_W-1:0]    cfg_wdata,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  flia_pkg::req_item_t            req,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output flia_pkg::rsp_item_t            rsp,
    output logic                           ram_we,
    output logic [flia_pkg::IDX_W-1:0]     ram_waddr,
    output logic [flia_pkg::LINK_W-1:0]    ram_wdata,
    output logic [flia_pkg::IDX_W-1:0]     ram_raddr,
    input  logic [flia_pkg::LINK_W-1:0]    ram_rdata
);

    localparam logic [1:0] S_FILL = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0]                     state_reg, state_next;
    flia_pkg::req_item_t            item_reg, item_next;
    logic [flia_pkg::IDX_W-1:0]     head_reg, head_next;
    logic                           empty_reg, empty_next;
    logic [flia_pkg::CNT_W-1:0]     used_reg, used_next;
    logic [flia_pkg::POOL_W-1:0]    pool_size_reg;
    logic [flia_pkg::IDX_W-1:0]     fill_cnt_reg, fill_cnt_next;
    logic [flia_pkg::IDX_W-1:0]     fill_last_reg, fill_last_next;
    logic                           rsp_valid_reg, rsp_valid_next;
    flia_pkg::rsp_item_t            rsp_reg, rsp_next;

    logic [flia_pkg::POOL_W-1:0]    eff_size;
    logic                           out_free;
    logic                           commit;
    logic                           in_range;

    always_comb
    begin
        if (pool_size_reg == '0)
        begin
            eff_size = flia_pkg::POOL_W'(1);
        end
        else if (pool_size_reg > flia_pkg::POOL_MAX)
        begin
            eff_size = flia_pkg::POOL_MAX;
        end
        else
        begin
            eff_size = pool_size_reg;
        end
    end

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign commit    = (state_reg == S_EXEC) && out_free;
    assign in_range  = flia_pkg::POOL_W'(item_reg.slot_index) < eff_size;
    assign req_stall = (state_reg != S_IDLE);
    assign ram_raddr = head_reg;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        head_next      = head_reg;
        empty_next     = empty_reg;
        used_next      = used_reg;
        fill_cnt_next  = fill_cnt_reg;
        fill_last_next = fill_last_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = fill_cnt_reg;
        ram_wdata      = flia_pkg::END_MARK;

        case (state_reg)
            S_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = fill_cnt_reg;
                if (fill_cnt_reg == fill_last_reg)
                begin
                    ram_wdata  = flia_pkg::END_MARK;
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_wdata     = flia_pkg::LINK_W'(fill_cnt_reg) + 1'b1;
                    fill_cnt_next = fill_cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next  = req;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    state_next             = S_IDLE;
                    rsp_valid_next         = 1'b1;
                    rsp_next.granted_index = '0;
                    rsp_next.status        = flia_pkg::STATUS_OK;
                    case (item_reg.mode)
                        flia_pkg::MODE_ALLOC:
                        begin
                            if (empty_reg)
                            begin
                                rsp_next.status = flia_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                rsp_next.granted_index = head_reg;
                                if (ram_rdata >= flia_pkg::END_MARK)
                                begin
                                    empty_next = 1'b1;
                                end
                                else
                                begin
                                    head_next = ram_rdata[flia_pkg::IDX_W-1:0];
                                end
                                if (used_reg < flia_pkg::USED_MAX)
                                begin
                                    used_next = used_reg + 1'b1;
                                end
                            end
                        end
                        flia_pkg::MODE_RELEASE:
                        begin
                            if (!in_range)
                            begin
                                rsp_next.status = flia_pkg::STATUS_RANGE;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = item_reg.slot_index;
                                ram_wdata  = empty_reg ? flia_pkg::END_MARK
                                                       : flia_pkg::LINK_W'(head_reg);
                                head_next  = item_reg.slot_index;
                                empty_next = 1'b0;
                                if (used_reg != '0)
                                begin
                                    used_next = used_reg - 1'b1;
                                end
                            end
                        end
                        flia_pkg::MODE_REINIT:
                        begin
                            head_next      = '0;
                            empty_next     = 1'b0;
                            used_next      = '0;
                            fill_cnt_next  = '0;
                            fill_last_next = flia_pkg::IDX_W'(eff_size - 1'b1);
                            state_next     = S_FILL;
                        end
                        default:
                        begin
                        end
                    endcase
                    rsp_next.used_slots = used_next;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FILL;
            head_reg      <= '0;
            empty_reg     <= 1'b0;
            used_reg      <= '0;
            pool_size_reg <= flia_pkg::POOL_RESET;
            fill_cnt_reg  <= '0;
            fill_last_reg <= flia_pkg::IDX_W'(flia_pkg::MAX_SLOTS - 1);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            empty_reg     <= empty_next;
            used_reg      <= used_next;
            fill_cnt_reg  <= fill_cnt_next;
            fill_last_reg <= fill_last_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                pool_size_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the free list index allocator top level.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import flia_pkg::*;

    localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
    localparam int unsigned HOLD_CYCLES = 600;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [POOL_W-1:0] cfg_wdata = '0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_item_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_item_t rsp;

    free_list_index_allocator_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    logic [POOL_W-1:0] fl_pool;
    logic [IDX_W-1:0]  fl_head;
    logic              fl_dry;
    logic [LINK_W-1:0] fl_link [MAX_SLOTS];
    logic [CNT_W-1:0]  fl_used;

    int unsigned taken_q [$];
    req_item_t   op_q [$];
    rsp_item_t   outcome_q [$];

    int unsigned n_queued = 0;
    int unsigned n_accepted = 0;
    int unsigned n_bad = 0;
    int unsigned tx_gap = 0;
    int unsigned rx_gap = 0;
    int unsigned hold_left = 0;
    logic        hold_start = 1'b0;
    logic        idle_on = 1'b1;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int unsigned live_size();
        if (fl_pool == '0)
            return 1;
        if (fl_pool > POOL_MAX)
            return MAX_SLOTS;
        return 32'(fl_pool);
    endfunction

    function automatic void rebuild_list();
        int unsigned sz;
        sz = live_size();
        for (int unsigned k = 0; k + 1 < sz; k++)
            fl_link[k] = LINK_W'(k + 1);
        fl_link[sz - 1] = END_MARK;
        fl_head = '0;
        fl_dry = 1'b0;
    endfunction

    function automatic rsp_item_t apply_op(req_item_t op);
        rsp_item_t r;
        logic [LINK_W-1:0] nxt;
        r = '0;
        r.status = STATUS_OK;
        case (op.mode)
            MODE_ALLOC:
            begin
                if (fl_dry)
                    r.status = STATUS_EMPTY;
                else
                begin
                    nxt = fl_link[fl_head];
                    r.granted_index = fl_head;
                    taken_q.push_back(32'(fl_head));
                    if (nxt >= END_MARK)
                        fl_dry = 1'b1;
                    else
                        fl_head = nxt[IDX_W-1:0];
                    if (fl_used < USED_MAX)
                        fl_used = fl_used + 1'b1;
                end
            end
            MODE_RELEASE:
            begin
                if (op.slot_index >= live_size())
                    r.status = STATUS_RANGE;
                else
                begin
                    fl_link[op.slot_index] = fl_dry ? END_MARK : LINK_W'(fl_head);
                    fl_head = op.slot_index;
                    fl_dry = 1'b0;
                    if (fl_used != '0)
                        fl_used = fl_used - 1'b1;
                    for (int k = 0; k < taken_q.size(); k++)
                    begin
                        if (taken_q[k] == 32'(op.slot_index))
                        begin
                            taken_q.delete(k);
                            break;
                        end
                    end
                end
            end
            MODE_REINIT:
            begin
                rebuild_list();
                fl_used = '0;
                taken_q.delete();
            end
            default:
            begin
            end
        endcase
        r.used_slots = fl_used;
        return r;
    endfunction

    // Driver: present queued items, hold while stalled, predict on accept.
    always @(posedge clk or negedge rst_n)
    begin : drv
        rsp_item_t due;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            tx_gap <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                due = apply_op(req);
                outcome_q.push_back(due);
                n_accepted++;
            end
            if (!req_valid || !req_stall)
            begin
                if (tx_gap != 0)
                begin
                    tx_gap <= tx_gap - 1;
                    req_valid <= 1'b0;
                end
                else if (op_q.size() != 0 && idle_on && $urandom_range(0, 5) == 0)
                begin
                    tx_gap <= $urandom_range(0, 12);
                    req_valid <= 1'b0;
                end
                else if (op_q.size() != 0)
                begin
                    req <= op_q.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted result against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : mon
        rsp_item_t want;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            rx_gap <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (outcome_q.size() == 0)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("unexpected item: index %0d status %0d used %0d",
                                 rsp.granted_index, rsp.status, rsp.used_slots);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (rsp.granted_index !== want.granted_index ||
                        rsp.status !== want.status ||
                        rsp.used_slots !== want.used_slots)
                    begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                     want.granted_index, want.status, want.used_slots,
                                     rsp.granted_index, rsp.status, rsp.used_slots);
                    end
                end
            end
            if (rx_gap != 0)
            begin
                rx_gap <= rx_gap - 1;
                rsp_stall <= 1'b1;
            end
            else if (hold_left != 0)
                rsp_stall <= 1'b1;
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                rx_gap <= $urandom_range(0, 12);
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_start)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    task automatic push_op(logic [MODE_W-1:0] m, int unsigned idx);
        req_item_t it;
        it.mode = m;
        it.slot_index = IDX_W'(idx);
        op_q.push_back(it);
        n_queued++;
    endtask

    task automatic drain();
        while (n_accepted != n_queued || outcome_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_pool(int unsigned v);
        drain();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= POOL_W'(v);
        fl_pool = POOL_W'(v);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_ops(int unsigned n);
        int unsigned left;
        int unsigned pick;
        int unsigned sz;
        int unsigned j;
        left = n;
        while (left != 0)
        begin
            while (n_queued - n_accepted > 1)
                @(negedge clk);
            for (j = 0; j < 6 && left != 0; j++)
            begin
                sz = live_size();
                pick = $urandom_range(0, 99);
                if (pick < 50 || (pick < 85 && taken_q.size() == 0))
                    push_op(MODE_ALLOC, $urandom_range(0, 1023));
                else if (pick < 85)
                    push_op(MODE_RELEASE, taken_q[$urandom_range(0, taken_q.size() - 1)]);
                else if (pick < 90)
                    push_op(MODE_RELEASE, $urandom_range(0, 1023));
                else if (pick < 93)
                    push_op(MODE_RELEASE, $urandom_range(0, sz - 1));
                else if (pick < 96)
                    push_op(MODE_NOP, $urandom_range(0, 1023));
                else
                    push_op(MODE_REINIT, $urandom_range(0, 1023));
                left--;
            end
        end
    endtask

    initial
    begin
        int unsigned pool_plan [10] = '{8, 1, 3, 1024, 0, 2047, 64, 1025, 0, 5};
        fl_pool = POOL_RESET;
        rebuild_list();
        fl_used = '0;
        pool_plan[8] = $urandom_range(1, 2047);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        push_op(MODE_ALLOC, 0);
        push_op(MODE_ALLOC, 1023);
        push_op(MODE_RELEASE, 0);
        push_op(MODE_ALLOC, 0);
        push_op(MODE_RELEASE, 1023);
        push_op(MODE_NOP, 1023);
        push_op(MODE_ALLOC, 0);
        push_op(MODE_REINIT, 1023);

        write_pool(2);
        push_op(MODE_REINIT, 0);
        push_op(MODE_ALLOC, 0);
        push_op(MODE_ALLOC, 0);
        push_op(MODE_ALLOC, 0);
        push_op(MODE_RELEASE, 2);
        push_op(MODE_RELEASE, 1023);
        push_op(MODE_RELEASE, 1);
        push_op(MODE_RELEASE, 1);
        push_op(MODE_RELEASE, 0);
        push_op(MODE_ALLOC, 0);
        push_op(MODE_ALLOC, 0);
        push_op(MODE_ALLOC, 0);

        write_pool(0);
        push_op(MODE_REINIT, 0);
        push_op(MODE_ALLOC, 0);
        push_op(MODE_ALLOC, 0);
        push_op(MODE_RELEASE, 1);
        push_op(MODE_RELEASE, 0);

        write_pool(2047);
        push_op(MODE_RELEASE, 1023);

        // Loop one slot onto itself, then allocate from it repeatedly.
        drain();
        idle_on <= 1'b0;
        push_op(MODE_REINIT, 0);
        push_op(MODE_RELEASE, 5);
        push_op(MODE_RELEASE, 5);
        for (int k = 0; k < 8; k++)
            push_op(MODE_ALLOC, $urandom_range(0, 1023));
        push_op(MODE_REINIT, 0);
        drain();
        idle_on <= 1'b1;

        for (int p = 0; p < 10; p++)
        begin
            write_pool(pool_plan[p]);
            idle_on <= (p != 9) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) != 0)
                push_op(MODE_REINIT, $urandom_range(0, 1023));
            if (p == 3)
            begin
                @(posedge clk);
                hold_start <= 1'b1;
                @(posedge clk);
                hold_start <= 1'b0;
            end
            random_ops(36);
        end

        drain();
        repeat (20) @(posedge clk);
        if (n_bad == 0 && outcome_q.size() == 0)
            $display("[free_list_index_allocator_top] OK");
        else
            $display("[free_list_index_allocator_top] ERROR");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("[free_list_index_allocator_top] ERROR");
        $finish;
    end

endmodule
